/* design/bxf_pkg.sv */
// Shared types and constants of the 3x3 box filter.
package bxf_pkg;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int HEIGHT_LIMIT  = 4096;
   localparam int MIN_DIM       = 3;
   localparam int KERNEL_SIZE   = 3;

   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 1;
   localparam int ROW_W     = 13;   // holds HEIGHT_LIMIT itself
   localparam int CH_W      = 8;
   localparam int SUM_W     = 12;   // 9 x 255
   localparam int RECIP_W   = 13;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam int RECIP_SHIFT = 16;

   localparam logic [RECIP_W-1:0] RECIP_NINE   = 13'd7282;   // 2^16 / 9, rounded up
   localparam logic [CFG_W-1:0]   WIDTH_RESET  = 13'd640;
   localparam logic [CFG_W-1:0]   HEIGHT_RESET = 13'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACT_PIXEL = 1'b0,
      ACT_DRAIN = 1'b1
   } action_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_type;

   // per-transaction control travelling down the pipe
   typedef struct packed {
      logic pixel;      // touches line stores and window
      logic emit;       // produces a result
      logic interior;   // result is a real mean, else zero
      logic last;       // final result of the frame
   } item_type;

endpackage

/* design/bxf_line_mem.sv */
// Line store: one write port, one registered read port, read-first.
module bxf_line_mem #(
   parameter int DEPTH = bxf_pkg::MAX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  bxf_pkg::rgb_type         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output bxf_pkg::rgb_type         rd_data
);
   import bxf_pkg::*;

   rgb_type mem [DEPTH];
   rgb_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bxf_ctrl.sv */
// Frame position counters, config registers and per-transaction decisions.
module bxf_ctrl #(
   parameter int MAX_WIDTH = bxf_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bxf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bxf_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                          accept,
   input  logic                          action,
   output logic                          take,
   output bxf_pkg::item_type             item,
   output logic [$clog2(MAX_WIDTH)-1:0]  addr
);
   import bxf_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (WW > CFG_W) ? WW : CFG_W;

   logic [CFG_W-1:0] width_ff, height_ff;
   logic [AW-1:0]    col_ff, col_in, col_sel;
   logic [ROW_W-1:0] row_ff, row_in, h_eff;
   logic [WW-1:0]    drain_ff, drain_in, w_eff, w_m1;
   logic [CW-1:0]    w_ext, w_clamp;
   logic             frame_in, col_last, due;

   // clamp registers into the usable range
   always_comb begin
      w_ext = CW'(width_ff);
      if (w_ext < CW'(MIN_DIM)) begin
         w_clamp = CW'(MIN_DIM);
      end else if (w_ext > CW'(MAX_WIDTH)) begin
         w_clamp = CW'(MAX_WIDTH);
      end else begin
         w_clamp = w_ext;
      end
      w_eff = w_clamp[WW-1:0];
      w_m1  = w_eff - WW'(1);

      if (height_ff < CFG_W'(MIN_DIM)) begin
         h_eff = ROW_W'(MIN_DIM);
      end else if (height_ff > CFG_W'(HEIGHT_LIMIT)) begin
         h_eff = ROW_W'(HEIGHT_LIMIT);
      end else begin
         h_eff = ROW_W'(height_ff);
      end
   end

   always_comb begin
      frame_in = (row_ff >= h_eff);
      col_sel  = (WW'(col_ff) >= w_eff) ? w_m1[AW-1:0] : col_ff;
      col_last = (WW'(col_sel) == w_m1);
      // position row*w+col beyond the first w+1 pixels
      due      = (row_ff >= ROW_W'(2)) || ((row_ff == ROW_W'(1)) && (col_sel != '0));

      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      take     = 1'b0;
      item     = '0;

      if (accept) begin
         if (action == ACT_DRAIN) begin
            if (frame_in && (drain_ff <= w_eff)) begin
               take      = 1'b1;
               item.emit = 1'b1;
               item.last = (drain_ff == w_eff);
               if (item.last) begin
                  col_in   = '0;
                  row_in   = '0;
                  drain_in = '0;
               end else begin
                  drain_in = drain_ff + WW'(1);
               end
            end
         end else if (!frame_in) begin
            take          = 1'b1;
            item.pixel    = 1'b1;
            item.emit     = due;
            item.interior = (col_sel >= AW'(2)) && (row_ff >= ROW_W'(2));
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_sel + AW'(1);
            end
         end
      end
   end

   assign addr = col_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         drain_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
      end
   end

endmodule

/* design/bxf_filter.sv */
// Window, sum and scaling pipeline with the result register.
module bxf_filter #(
   parameter int MAX_WIDTH = bxf_pkg::MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  bxf_pkg::item_type            item,
   input  logic [$clog2(MAX_WIDTH)-1:0] addr,
   input  bxf_pkg::rgb_type             pix,
   input  bxf_pkg::rgb_type             upper_rd,
   input  bxf_pkg::rgb_type             lower_rd,
   output logic                         in_free,
   output logic                         upper_we,
   output logic [$clog2(MAX_WIDTH)-1:0] upper_waddr,
   output bxf_pkg::rgb_type             upper_wdata,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bxf_pkg::rgb_type             rsp_rgb,
   output logic                         rsp_last
);
   import bxf_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic                 a_v_ff, b_v_ff, c_v_ff, o_v_ff;
   item_type             a_item_ff, b_item_ff, c_item_ff;
   logic [AW-1:0]        a_addr_ff;
   rgb_type              a_pix_ff;
   rgb_type              win_ff [KERNEL_SIZE][KERNEL_SIZE];
   logic [SUM_W-1:0]     c_sum_ff [3];
   rgb_type              o_rgb_ff;
   logic                 o_last_ff;

   logic                 o_free, c_free, b_free, a_free, c_mv, b_mv, a_mv;
   logic [SUM_W-1:0]     col_sum [3][KERNEL_SIZE];
   logic [SUM_W-1:0]     sum [3];
   logic [PROD_W-1:0]    prod [3];

   always_comb begin
      o_free = !o_v_ff || rsp_ready;
      c_mv   = c_v_ff && o_free;
      c_free = !c_v_ff || o_free;
      b_mv   = b_v_ff && c_free;
      b_free = !b_v_ff || c_free;
      a_mv   = a_v_ff && b_free;
      a_free = !a_v_ff || b_free;
   end

   assign in_free     = a_free;
   // upper row takes the old lower-row entry once it has been read
   assign upper_we    = a_mv && a_item_ff.pixel;
   assign upper_waddr = a_addr_ff;
   assign upper_wdata = lower_rd;

   // column sums first, then across the three columns
   always_comb begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
         col_sum[0][j] = SUM_W'(win_ff[0][j].red) + SUM_W'(win_ff[1][j].red)
                       + SUM_W'(win_ff[2][j].red);
         col_sum[1][j] = SUM_W'(win_ff[0][j].green) + SUM_W'(win_ff[1][j].green)
                       + SUM_W'(win_ff[2][j].green);
         col_sum[2][j] = SUM_W'(win_ff[0][j].blue) + SUM_W'(win_ff[1][j].blue)
                       + SUM_W'(win_ff[2][j].blue);
      end
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch]  = col_sum[ch][0] + col_sum[ch][1] + col_sum[ch][2];
         prod[ch] = PROD_W'(c_sum_ff[ch]) * PROD_W'(RECIP_NINE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
         for (int i = 0; i < KERNEL_SIZE; i++) begin
            for (int j = 0; j < KERNEL_SIZE; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         if (a_free) a_v_ff <= take;
         if (b_free) b_v_ff <= a_mv;
         if (c_free) c_v_ff <= b_mv;
         if (o_free) o_v_ff <= c_mv && c_item_ff.emit;
         if (a_mv && a_item_ff.pixel) begin
            for (int i = 0; i < KERNEL_SIZE; i++) begin
               for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
                  win_ff[i][j] <= win_ff[i][j+1];
               end
            end
            win_ff[0][KERNEL_SIZE-1] <= upper_rd;
            win_ff[1][KERNEL_SIZE-1] <= lower_rd;
            win_ff[2][KERNEL_SIZE-1] <= a_pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         a_item_ff <= item;
         a_addr_ff <= addr;
         a_pix_ff  <= pix;
      end
      if (a_mv) begin
         b_item_ff <= a_item_ff;
      end
      if (b_mv) begin
         c_item_ff <= b_item_ff;
         for (int ch = 0; ch < 3; ch++) begin
            c_sum_ff[ch] <= sum[ch];
         end
      end
      if (c_mv) begin
         o_last_ff <= c_item_ff.last;
         if (c_item_ff.interior) begin
            o_rgb_ff.red   <= prod[0][RECIP_SHIFT +: CH_W];
            o_rgb_ff.green <= prod[1][RECIP_SHIFT +: CH_W];
            o_rgb_ff.blue  <= prod[2][RECIP_SHIFT +: CH_W];
         end else begin
            o_rgb_ff <= '0;
         end
      end
   end

   assign rsp_valid = o_v_ff;
   assign rsp_rgb   = o_rgb_ff;
   assign rsp_last  = o_last_ff;

endmodule

/* design/rgb_box_filter_3x3.sv */
// Top level of the streaming 3x3 RGB box filter.
// A taken transaction moves through stages a, b and c, then into the result register.
// Throughput: one transaction per cycle unless results stall, set by the single read ports.
// Results trail the pixel stream by image_width+1 transactions; drain ticks flush the tail.
// Reset (synchronous): clears pipeline valids, counters and window, sets 640x480.
// Line stores are not cleared; no clearing pass, entries are written before any use.
module rgb_box_filter_3x3 #(
   parameter int MAX_WIDTH = bxf_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // pixel / drain channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [bxf_pkg::CH_W-1:0]      req_red_in,
   input  logic [bxf_pkg::CH_W-1:0]      req_green_in,
   input  logic [bxf_pkg::CH_W-1:0]      req_blue_in,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bxf_pkg::CH_W-1:0]      rsp_red_out,
   output logic [bxf_pkg::CH_W-1:0]      rsp_green_out,
   output logic [bxf_pkg::CH_W-1:0]      rsp_blue_out,
   output logic                          rsp_frame_last,
   // config writes, only while idle
   input  logic                          csr_we,
   input  logic [bxf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bxf_pkg::CFG_W-1:0]     csr_wdata
);
   import bxf_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);

   logic          accept, take, upper_we, rsp_last;
   item_type      item;
   logic [AW-1:0] addr, upper_waddr;
   rgb_type       pix, upper_rd, lower_rd, upper_wdata, rsp_rgb;

   assign accept = req_valid && req_ready;
   assign pix    = '{red: req_red_in, green: req_green_in, blue: req_blue_in};

   // counters decide per transaction: ignored, pixel, or drain result
   bxf_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .action    (req_action),
      .take      (take),
      .item      (item),
      .addr      (addr)
   );

   // upper row: read on take, written back from stage a with the old lower entry.
   // The same column comes round again no sooner than three pixels later, so no forwarding.
   bxf_line_mem #(.DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (upper_we),
      .wr_addr (upper_waddr),
      .wr_data (upper_wdata),
      .rd_en   (take),
      .rd_addr (addr),
      .rd_data (upper_rd)
   );

   // lower row: read-first, new pixel written at the same address in the same cycle
   bxf_line_mem #(.DEPTH(MAX_WIDTH)) u_lower (
      .clock   (clock),
      .wr_en   (take && item.pixel),
      .wr_addr (addr),
      .wr_data (pix),
      .rd_en   (take),
      .rd_addr (addr),
      .rd_data (lower_rd)
   );

   bxf_filter #(.MAX_WIDTH(MAX_WIDTH)) u_filter (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .item        (item),
      .addr        (addr),
      .pix         (pix),
      .upper_rd    (upper_rd),
      .lower_rd    (lower_rd),
      .in_free     (req_ready),
      .upper_we    (upper_we),
      .upper_waddr (upper_waddr),
      .upper_wdata (upper_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_rgb     (rsp_rgb),
      .rsp_last    (rsp_last)
   );

   assign rsp_red_out    = rsp_rgb.red;
   assign rsp_green_out  = rsp_rgb.green;
   assign rsp_blue_out   = rsp_rgb.blue;
   assign rsp_frame_last = rsp_last;

endmodule

/* design/bxf_checker.sv */
// Port-level checks of the box filter, bound to the top level.
module bxf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_red_out,
   input logic [7:0] rsp_green_out,
   input logic [7:0] rsp_blue_out,
   input logic       rsp_frame_last
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out)
         && $stable(rsp_green_out) && $stable(rsp_blue_out) && $stable(rsp_frame_last))
      else $error("result changed while stalled");

   // frame end is always a border pixel
   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> rsp_red_out == 8'd0 && rsp_green_out == 8'd0
         && rsp_blue_out == 8'd0)
      else $error("final result of frame not zero");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input only backs up when the pipe is full behind a stalled result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

endmodule

bind rgb_box_filter_3x3 bxf_checker u_bxf_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench for the streaming 3x3 RGB box filter.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bxf_pkg::*;

   // ---------------------------------------------------------------
   // Run constants
   // ---------------------------------------------------------------
   localparam int unsigned RANDOM_ITEMS  = 540;     // effective transactions in the random part
   localparam int unsigned SETTLE_CYCLES = 8;       // pipe is 4 deep, allow a margin
   localparam int unsigned CYCLE_LIMIT   = 400_000;

   // which side of the link idles in the current phase
   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef enum logic {
      ROW_WRITE,
      ROW_ITEM
   } row_kind_type;

   // one filtered pixel as it leaves the block
   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            last;
   } filtered_px_type;

   // one line of the directed table: a register write or a transaction,
   // optionally with its outcome written out by hand
   typedef struct packed {
      row_kind_type    kind;
      csr_index_type   reg_idx;
      logic [CFG_W-1:0] reg_val;
      action_type      act;
      rgb_type         px;
      bit              typed;
      bit              has;
      filtered_px_type want;
   } dir_row_type;

   localparam filtered_px_type BORDER_PX = '0;
   localparam filtered_px_type BORDER_LAST = {8'h00, 8'h00, 8'h00, 1'b1};
   localparam filtered_px_type FULL_PX = {8'hFF, 8'hFF, 8'hFF, 1'b0};
   localparam rgb_type WHITE = {8'hFF, 8'hFF, 8'hFF};
   localparam rgb_type BLACK = {8'h00, 8'h00, 8'h00};

   // ---------------------------------------------------------------
   // Clock, reset and DUT
   // ---------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_valid = 1'b0;
   logic          req_ready;
   action_type    req_action = ACT_PIXEL;
   logic [CH_W-1:0] req_red_in = '0;
   logic [CH_W-1:0] req_green_in = '0;
   logic [CH_W-1:0] req_blue_in = '0;

   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [CH_W-1:0] rsp_red_out;
   logic [CH_W-1:0] rsp_green_out;
   logic [CH_W-1:0] rsp_blue_out;
   logic          rsp_frame_last;

   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0] csr_wdata = '0;

   // travels with each directed transaction: hand-written outcome, if any
   logic            row_is_typed = 1'b0;
   logic            row_typed_has = 1'b0;
   filtered_px_type row_typed_px = '0;

   always #10 clock = ~clock;

   rgb_box_filter_3x3 dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // ---------------------------------------------------------------
   // Filter model: own copy of the line stores, window and counters
   // ---------------------------------------------------------------
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   rgb_type          top_line [MAX_WIDTH_DEF];   // two rows back
   rgb_type          mid_line [MAX_WIDTH_DEF];   // previous row
   rgb_type          win_px [KERNEL_SIZE][KERNEL_SIZE];
   int unsigned      next_col;
   int unsigned      next_row;                   // == height once all pixels are in
   int unsigned      sent_count;                 // outputs of this frame so far

   filtered_px_type  filtered_q [$];             // outputs still owed by the DUT
   int unsigned      effective_items = 0;        // transactions that did something
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count = 0;
   idle_mode_type    idle_mode = IDLE_NONE;
   bit               paused_once = 1'b0;

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                             input int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_counts();
      next_col = 0;
      next_row = 0;
      sent_count = 0;
   endfunction

   function automatic void clear_model();
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
         top_line[i] = '0;
         mid_line[i] = '0;
      end
      for (int i = 0; i < KERNEL_SIZE; i++)
         for (int j = 0; j < KERNEL_SIZE; j++)
            win_px[i][j] = '0;
      restart_counts();
   endfunction

   // mean of the nine window pixels per channel, border forced to zero;
   // also steps the output count and closes the frame on its last output
   function automatic filtered_px_type next_output(input bit interior,
                                                   input int unsigned total);
      filtered_px_type px;
      int unsigned     sum_r;
      int unsigned     sum_g;
      int unsigned     sum_b;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (int i = 0; i < KERNEL_SIZE; i++)
         for (int j = 0; j < KERNEL_SIZE; j++) begin
            sum_r += win_px[i][j].red;
            sum_g += win_px[i][j].green;
            sum_b += win_px[i][j].blue;
         end
      // divide by nine as multiply-and-shift
      px.red   = interior ? CH_W'((sum_r * RECIP_NINE) >> RECIP_SHIFT) : '0;
      px.green = interior ? CH_W'((sum_g * RECIP_NINE) >> RECIP_SHIFT) : '0;
      px.blue  = interior ? CH_W'((sum_b * RECIP_NINE) >> RECIP_SHIFT) : '0;
      px.last  = (sent_count == total - 1);
      sent_count++;
      if (px.last) restart_counts();
      return px;
   endfunction

   task automatic box_mean_step(input action_type act, input rgb_type px,
                                output bit took_effect, output bit has_out,
                                output filtered_px_type res);
      int unsigned w;
      int unsigned h;
      int unsigned total;
      int unsigned col;
      int unsigned pos;
      bit          interior;
      w = clamp_dim(width_reg, MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, HEIGHT_LIMIT);
      total = w * h;
      took_effect = 1'b0;
      has_out = 1'b0;
      res = '0;
      if (act == ACT_DRAIN) begin
         // only flushes once every pixel of the frame is in
         if (next_row >= h && sent_count < total) begin
            took_effect = 1'b1;
            has_out = 1'b1;
            res = next_output(1'b0, total);
         end
      end else if (next_row < h) begin
         col = (next_col >= w) ? w - 1 : next_col;
         for (int i = 0; i < KERNEL_SIZE; i++)
            for (int j = 0; j < KERNEL_SIZE - 1; j++)
               win_px[i][j] = win_px[i][j+1];
         win_px[0][KERNEL_SIZE-1] = top_line[col];
         win_px[1][KERNEL_SIZE-1] = mid_line[col];
         win_px[2][KERNEL_SIZE-1] = px;
         top_line[col] = mid_line[col];
         mid_line[col] = px;
         pos = next_row * w + col;
         interior = (col >= 2 && next_row >= 2);
         if (col + 1 >= w) begin
            next_col = 0;
            next_row++;
         end else begin
            next_col = col + 1;
         end
         took_effect = 1'b1;
         // output (r,c) leaves with input (r+1,c+1)
         if (pos >= w + 1) begin
            has_out = 1'b1;
            res = next_output(interior, total);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [CH_W-1:0] got,
                                  input logic [CH_W-1:0] want);
      $display("%0t ns: mismatch on %s, got %h wanted %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------
   // Monitor: everything sampled at the edge, before any NBA lands
   // ---------------------------------------------------------------
   always @(posedge clock) begin : watch_link
      filtered_px_type model_px;
      filtered_px_type want;
      bit              took;
      bit              has;
      if (reset) begin
         clear_model();
      end else begin
         // a register write takes effect at once and restarts the frame
         if (csr_we) begin
            if (csr_index == CSR_IMAGE_WIDTH) width_reg = csr_wdata;
            else height_reg = csr_wdata;
            restart_counts();
         end
         if (req_valid && req_ready) begin
            box_mean_step(req_action, {req_red_in, req_green_in, req_blue_in},
                          took, has, model_px);
            // directed rows may carry their outcome written out by hand
            if (row_is_typed) begin
               has = row_typed_has;
               model_px = row_typed_px;
            end
            if (has) filtered_q.push_back(model_px);
            if (took) effective_items++;
         end
         if (rsp_valid && rsp_ready) begin
            if (filtered_q.size() == 0) begin
               report_mismatch("result with nothing outstanding", rsp_red_out, '0);
            end else begin
               want = filtered_q.pop_front();
               if (rsp_red_out !== want.red) report_mismatch("red", rsp_red_out, want.red);
               if (rsp_green_out !== want.green)
                  report_mismatch("green", rsp_green_out, want.green);
               if (rsp_blue_out !== want.blue)
                  report_mismatch("blue", rsp_blue_out, want.blue);
               if (rsp_frame_last !== want.last)
                  report_mismatch("frame_last", CH_W'(rsp_frame_last), CH_W'(want.last));
            end
         end
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      case (idle_mode)
         IDLE_RECEIVER: rsp_ready <= ($urandom_range(99) >= 59);
         IDLE_BOTH:     rsp_ready <= ($urandom_range(99) >= 38);
         default:       rsp_ready <= 1'b1;
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: watchdog expired", $time);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------
   function automatic logic [CH_W-1:0] random_channel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return CH_W'($urandom_range(255));
      endcase
   endfunction

   function automatic rgb_type random_px();
      return {random_channel(), random_channel(), random_channel()};
   endfunction

   // one transaction; valid is only dropped when a gap is taken
   task automatic send_item(input action_type act, input rgb_type px);
      int unsigned gap_pct;
      case (idle_mode)
         IDLE_SENDER: gap_pct = 59;
         IDLE_BOTH:   gap_pct = 38;
         default:     gap_pct = 0;
      endcase
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_red_in   <= px.red;
      req_green_in <= px.green;
      req_blue_in  <= px.blue;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the sender until every owed output has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (filtered_q.size() != 0);
      paused_once = 1'b1;
   endtask

   // registers only change with the pipe empty
   task automatic write_reg(input csr_index_type idx, input logic [CFG_W-1:0] val);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // a full frame plus its drain tail, with some noise mixed in;
   // a cut-short frame is simply abandoned at a random pixel
   task automatic send_frame(input int unsigned w, input int unsigned h,
                             input bit cut_short);
      int unsigned npix;
      int unsigned cut_at;
      npix = w * h;
      cut_at = cut_short ? $urandom_range(npix - 1) : npix;
      for (int unsigned i = 0; i < npix; i++) begin
         if (i == cut_at) break;
         // drain while pixels are still due: ignored
         if ($urandom_range(39) == 0) send_item(ACT_DRAIN, random_px());
         if ((!paused_once && i == npix / 2) || $urandom_range(63) == 0)
            hold_until_drained();
         send_item(ACT_PIXEL, random_px());
      end
      if (!cut_short) begin
         // pixels after the frame is complete: ignored
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) send_item(ACT_PIXEL, random_px());
         repeat (w + 1) begin
            if ($urandom_range(9) == 0) send_item(ACT_PIXEL, random_px());
            send_item(ACT_DRAIN, random_px());
         end
         // nothing pending after the last output: ignored
         if ($urandom_range(3) == 0) send_item(ACT_DRAIN, random_px());
      end
   endtask

   function automatic logic [CFG_W-1:0] pick_dim(input bit is_width);
      if ($urandom_range(11) == 0) return CFG_W'($urandom_range(2));   // clamps up to 3
      return is_width ? CFG_W'($urandom_range(3, 10)) : CFG_W'($urandom_range(3, 6));
   endfunction

   function automatic dir_row_type item_row(input action_type act, input rgb_type px,
                                            input bit typed, input bit has,
                                            input filtered_px_type want);
      return {ROW_ITEM, CSR_IMAGE_WIDTH, {CFG_W{1'b0}}, act, px, typed, has, want};
   endfunction

   function automatic dir_row_type reg_row(input csr_index_type idx,
                                           input logic [CFG_W-1:0] val);
      return {ROW_WRITE, idx, val, ACT_PIXEL, BLACK, 1'b0, 1'b0, BORDER_PX};
   endfunction

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   dir_row_type directed_rows [$];

   initial begin
      int unsigned base_items;
      int unsigned phase;
      int unsigned frames;
      logic [CFG_W-1:0] w_val;
      logic [CFG_W-1:0] h_val;

      // -- directed table --
      // at 640x480 nothing can leave yet, a drain is refused
      directed_rows.push_back(item_row(ACT_PIXEL, WHITE, 1, 0, BORDER_PX));
      directed_rows.push_back(item_row(ACT_PIXEL, BLACK, 1, 0, BORDER_PX));
      directed_rows.push_back(item_row(ACT_PIXEL, {8'h80, 8'h7F, 8'h01}, 1, 0, BORDER_PX));
      directed_rows.push_back(item_row(ACT_DRAIN, WHITE, 1, 0, BORDER_PX));
      // out-of-range sizes clamp to the 3x3 minimum; the write restarts the frame
      directed_rows.push_back(reg_row(CSR_IMAGE_WIDTH, 13'd0));
      directed_rows.push_back(reg_row(CSR_IMAGE_HEIGHT, 13'd2));
      // all-white 3x3: four silent pixels, four border zeros, then the full centre
      repeat (4) directed_rows.push_back(item_row(ACT_PIXEL, WHITE, 1, 0, BORDER_PX));
      repeat (4) directed_rows.push_back(item_row(ACT_PIXEL, WHITE, 1, 1, BORDER_PX));
      directed_rows.push_back(item_row(ACT_PIXEL, WHITE, 1, 1, FULL_PX));
      // frame already complete: pixel dropped
      directed_rows.push_back(item_row(ACT_PIXEL, BLACK, 1, 0, BORDER_PX));
      // drain tail, last one flags end of frame
      repeat (3) directed_rows.push_back(item_row(ACT_DRAIN, BLACK, 1, 1, BORDER_PX));
      directed_rows.push_back(item_row(ACT_DRAIN, BLACK, 1, 1, BORDER_LAST));
      // new frame already open, so a further drain is refused
      directed_rows.push_back(item_row(ACT_DRAIN, BLACK, 1, 0, BORDER_PX));
      // start of the next frame, left to the model
      directed_rows.push_back(item_row(ACT_PIXEL, {8'h12, 8'hED, 8'h5A}, 0, 0, BORDER_PX));
      directed_rows.push_back(item_row(ACT_PIXEL, {8'hA5, 8'h3C, 8'hC3}, 0, 0, BORDER_PX));
      directed_rows.push_back(item_row(ACT_PIXEL, {8'h01, 8'hFE, 8'h80}, 0, 0, BORDER_PX));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_WRITE) begin
            write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
         end else begin
            row_is_typed  <= directed_rows[k].typed;
            row_typed_has <= directed_rows[k].has;
            row_typed_px  <= directed_rows[k].want;
            send_item(directed_rows[k].act, directed_rows[k].px);
         end
      end
      row_is_typed <= 1'b0;

      // -- random frames, small sizes, all idling patterns in turn --
      base_items = effective_items;
      phase = 0;
      while (effective_items - base_items < RANDOM_ITEMS) begin
         idle_mode = idle_mode_type'(phase % 4);
         w_val = pick_dim(1'b1);
         h_val = pick_dim(1'b0);
         write_reg(CSR_IMAGE_WIDTH, w_val);
         write_reg(CSR_IMAGE_HEIGHT, h_val);
         frames = $urandom_range(1, 3);
         // back-to-back frames roll over without a register write
         for (int unsigned f = 0; f < frames; f++)
            send_frame(clamp_dim(w_val, MAX_WIDTH_DEF), clamp_dim(h_val, HEIGHT_LIMIT),
                       f == frames - 1 && $urandom_range(4) == 0);
         phase++;
      end

      // -- widest row: clamps to the store depth, well short of a line, nothing leaves --
      idle_mode = IDLE_NONE;
      write_reg(CSR_IMAGE_WIDTH, $urandom_range(1) ? 13'd4096 : 13'd8191);
      write_reg(CSR_IMAGE_HEIGHT, $urandom_range(1) ? 13'd4097 : 13'd8191);
      repeat ($urandom_range(20, 40)) send_item(ACT_PIXEL, random_px());
      // pixels still due, so this drain is refused
      send_item(ACT_DRAIN, random_px());

      // -- tallest frame with a narrow row: interior results, frame left open --
      idle_mode = IDLE_BOTH;
      write_reg(CSR_IMAGE_WIDTH, CFG_W'($urandom_range(3, 6)));
      write_reg(CSR_IMAGE_HEIGHT, $urandom_range(1) ? 13'd4096 : 13'd8191);
      repeat ($urandom_range(30, 60)) send_item(ACT_PIXEL, random_px());

      // -- wind down --
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && filtered_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* rgb_box_filter_3x3.f */
design/bxf_pkg.sv
design/bxf_line_mem.sv
design/bxf_ctrl.sv
design/bxf_filter.sv
design/rgb_box_filter_3x3.sv
design/bxf_checker.sv
dv/tb_top.sv
